@@ rtl/core/hec_pkg.sv @@
// hec_pkg: types, constants and bit-placement helpers of the hamming codec
// used by hamming_encode_correct_unit and hec_syndrome; no dependencies

package hec_pkg;

   localparam int WordWidth  = 63;
   localparam int SyndWidth  = 6;
   localparam int OrderWidth = 3;

   localparam logic [OrderWidth-1:0] OrderMin   = 3'd2;
   localparam logic [OrderWidth-1:0] OrderReset = 3'd6;

   typedef logic [WordWidth-1:0]  word_type;
   typedef logic [SyndWidth-1:0]  synd_type;
   typedef logic [OrderWidth-1:0] order_type;

   typedef enum logic {
      KIND_ENCODE = 1'b0,
      KIND_DECODE = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type kind;
      word_type word;
   } req_type;

   typedef struct packed {
      word_type code_word;
      synd_type syndrome;
      logic     corrected;
   } rsp_type;

   // ones in the low bits positions
   function automatic word_type low_mask(input synd_type bits);
      logic [WordWidth:0] t;
      t = ({{WordWidth{1'b0}}, 1'b1} << bits) - {{WordWidth{1'b0}}, 1'b1};
      return t[WordWidth-1:0];
   endfunction

   // info bits in order at the positions that are not powers of two
   function automatic word_type scatter_data(input word_type info);
      word_type cw;
      int       next;
      cw   = '0;
      next = 0;
      for (int p = 1; p <= WordWidth; p++) begin
         if ((p & (p - 1)) != 0) begin
            cw[p-1] = info[next];
            next++;
         end
      end
      return cw;
   endfunction

endpackage

@@ rtl/core/hec_syndrome.sv @@
// hec_syndrome: xor of the positions of all set bits of a codeword
// depends on hec_pkg

module hec_syndrome
   import hec_pkg::*;
(
   input  word_type code_vec,
   output synd_type synd
);

   always_comb begin
      synd = '0;
      for (int j = 0; j < SyndWidth; j++) begin
         for (int p = 1; p <= WordWidth; p++) begin
            if (((p >> j) & 1) != 0) begin
               synd[j] = synd[j] ^ code_vec[p-1];
            end
         end
      end
   end

endmodule

@@ rtl/core/hamming_encode_correct_unit.sv @@
// hamming_encode_correct_unit: top level of the hamming single error codec
// depends on hec_pkg and hec_syndrome
//
// usage
//  - req channel: kind selects encode of info bits or decode of a received word
//  - rsp channel: codeword (encoded or corrected), syndrome, corrected flag
//  - csr channel: writes the code order m, always ready; write only when idle
//  - order below 2 acts as 2, above MAX_ORDER acts as MAX_ORDER
//  - throughput: one request per cycle unless rsp_ready stalls the stages, set
//    by the three register stages (input placement and masking, syndrome xor
//    trees, parity/flip output)
//  - reset clears every stage valid bit and sets the order to 6
//  - when rsp_ready is low the stages fill up and hold; req_ready drops
//    only when all stages are occupied, nothing is lost or repeated

module hamming_encode_correct_unit
   import hec_pkg::*;
#(
   parameter int unsigned MAX_ORDER = 6
)(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data,
   input  logic      csr_valid,
   output logic      csr_ready,
   input  order_type csr_data
);

   localparam order_type OrderMax = order_type'(MAX_ORDER);

   order_type code_order_ff;
   order_type eff_order;
   synd_type  n_len;
   synd_type  k_len;
   word_type  s1_vec_in;

   logic      s1_valid_ff;
   kind_type  s1_kind_ff;
   word_type  s1_vec_ff;

   logic      s2_valid_ff;
   kind_type  s2_kind_ff;
   word_type  s2_vec_ff;
   synd_type  s2_synd_ff;
   synd_type  s2_synd_in;

   logic      rsp_valid_ff;
   rsp_type   rsp_data_ff;
   rsp_type   rsp_data_in;
   word_type  flip_vec;

   logic      out_en;
   logic      s2_en;
   logic      s1_en;

   assign out_en    = !rsp_valid_ff || rsp_ready;
   assign s2_en     = !s2_valid_ff || out_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_ready = s1_en;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_order_ff <= OrderReset;
      end else if (csr_valid) begin
         code_order_ff <= csr_data;
      end
   end

   always_comb begin
      if (code_order_ff < OrderMin) begin
         eff_order = OrderMin;
      end else if (code_order_ff > OrderMax) begin
         eff_order = OrderMax;
      end else begin
         eff_order = code_order_ff;
      end
      n_len = synd_type'((7'd1 << eff_order) - 7'd1);
      k_len = n_len - {{(SyndWidth-OrderWidth){1'b0}}, eff_order};
      if (req_data.kind == KIND_DECODE) begin
         s1_vec_in = req_data.word & low_mask(n_len);
      end else begin
         s1_vec_in = scatter_data(req_data.word & low_mask(k_len));
      end
   end

   // stage 1: placed or masked codeword
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_valid;
      end
      if (s1_en) begin
         s1_kind_ff <= req_data.kind;
         s1_vec_ff  <= s1_vec_in;
      end
   end

   hec_syndrome u_syndrome (
      .code_vec (s1_vec_ff),
      .synd     (s2_synd_in)
   );

   // stage 2: syndrome
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_en) begin
         s2_kind_ff <= s1_kind_ff;
         s2_vec_ff  <= s1_vec_ff;
         s2_synd_ff <= s2_synd_in;
      end
   end

   always_comb begin
      for (int p = 1; p <= WordWidth; p++) begin
         flip_vec[p-1] = (s2_synd_ff == synd_type'(p));
      end
      rsp_data_in.code_word = s2_vec_ff;
      rsp_data_in.syndrome  = '0;
      rsp_data_in.corrected = 1'b0;
      if (s2_kind_ff == KIND_DECODE) begin
         rsp_data_in.code_word = s2_vec_ff ^ flip_vec;
         rsp_data_in.syndrome  = s2_synd_ff;
         rsp_data_in.corrected = (s2_synd_ff != '0);
      end else begin
         for (int j = 0; j < SyndWidth; j++) begin
            rsp_data_in.code_word[(1 << j) - 1] = s2_synd_ff[j];
         end
      end
   end

   // stage 3: output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= s2_valid_ff;
      end
      if (out_en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
